// File: sv/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, constants and register codes of the preamp shaper and ADC
// emulator.
// ----------------------------------------------------------------------------
package psa_pkg;

	// Strips per read-out channel; the previous energy clears at each start
	localparam int CHANNEL_STRIPS = 128;
	// Largest sample count accepted; larger rates fall back to one sample
	localparam int MAX_SAMPLES    = 4;
	// Highest strip number carried by the strip index field
	localparam int STRIP_LIMIT    = 1023;

	// Field widths
	localparam int ENERGY_W = 24;
	localparam int STRIP_W  = 10;
	localparam int GAIN_W   = 24;
	localparam int PED_W    = 16;
	localparam int RATE_W   = 3;
	localparam int COUNT_W  = 16;
	localparam int SIDX_W   = 2;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_ADC              = 3'd0,
		REG_DECAY_QUARTER        = 3'd1,
		REG_DECAY_THIRD          = 3'd2,
		REG_DECAY_HALF           = 3'd3,
		REG_DECAY_TWO_THIRDS     = 3'd4,
		REG_DECAY_THREE_QUARTERS = 3'd5,
		REG_DECAY_FULL           = 3'd6
	} cfg_reg_t;

	// Reset values of the registers
	localparam logic [CFG_W-1:0] RST_MAX_ADC              = 16'd1023;
	localparam logic [CFG_W-1:0] RST_DECAY_QUARTER        = 16'd14623;
	localparam logic [CFG_W-1:0] RST_DECAY_THIRD          = 16'd8869;
	localparam logic [CFG_W-1:0] RST_DECAY_HALF           = 16'd3263;
	localparam logic [CFG_W-1:0] RST_DECAY_TWO_THIRDS     = 16'd1200;
	localparam logic [CFG_W-1:0] RST_DECAY_THREE_QUARTERS = 16'd728;
	localparam logic [CFG_W-1:0] RST_DECAY_FULL           = 16'd162;

	// Register contents handed from the register file to the datapath
	typedef struct packed {
		logic [CFG_W-1:0] max_adc;
		logic [CFG_W-1:0] decay_quarter;
		logic [CFG_W-1:0] decay_third;
		logic [CFG_W-1:0] decay_half;
		logic [CFG_W-1:0] decay_two_thirds;
		logic [CFG_W-1:0] decay_three_quarters;
		logic [CFG_W-1:0] decay_full;
	} cfg_t;

endpackage

// File: sv/psa_strip_if.sv
// ----------------------------------------------------------------------------
// psa_strip_if
// Strip channel: one strip's energy, index, gain, pedestal and sample rate.
// ----------------------------------------------------------------------------
interface psa_strip_if;
	logic                          valid;
	logic                          ready;
	logic [psa_pkg::ENERGY_W-1:0]  energy;
	logic [psa_pkg::STRIP_W-1:0]   strip_index;
	logic [psa_pkg::GAIN_W-1:0]    gain;
	logic [psa_pkg::PED_W-1:0]     pedestal;
	logic [psa_pkg::RATE_W-1:0]    sample_rate;

	modport source (output valid, energy, strip_index, gain, pedestal, sample_rate,
		input ready);
	modport sink (input valid, energy, strip_index, gain, pedestal, sample_rate,
		output ready);
endinterface

// File: sv/psa_sample_if.sv
// ----------------------------------------------------------------------------
// psa_sample_if
// Sample channel: one saturated ADC count with its index within the strip.
// ----------------------------------------------------------------------------
interface psa_sample_if;
	logic                         valid;
	logic                         ready;
	logic [psa_pkg::COUNT_W-1:0]  adc_count;
	logic [psa_pkg::SIDX_W-1:0]   sample_index;
	logic                         last_sample;

	modport source (output valid, adc_count, sample_index, last_sample, input ready);
	modport sink (input valid, adc_count, sample_index, last_sample, output ready);
endinterface

// File: sv/preamp_shaper_adc_emulator.sv
// Sequence: a one-sample strip passes ST_MUL_G and ST_EMIT into the output
// register; with rate r in 2..4 each sample passes ST_MUL_E, ST_MUL_P, ST_SUM,
// ST_MUL_G and ST_EMIT, all on the single shared 24x24 multiplier. A new
// strip is taken only in ST_IDLE; a held output stalls the sequencer.
// Reset: arst_n clears the sequencer, the output valid flag and the previous
// energy, and loads the registers with their reset values.
// ----------------------------------------------------------------------------
// preamp_shaper_adc_emulator
// Per-strip preamp shaping and ADC conversion on one multiplier under a
// small sequencer, with a one-entry output register.
// ----------------------------------------------------------------------------
module preamp_shaper_adc_emulator #(
	parameter int CHANNEL_STRIPS = psa_pkg::CHANNEL_STRIPS,
	parameter int MAX_SAMPLES    = psa_pkg::MAX_SAMPLES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	psa_strip_if.sink                      strip,
	psa_sample_if.source                   sample,
	input  logic                           cfg_we,
	input  logic [psa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psa_pkg::CFG_W-1:0]      cfg_data
);

	localparam int NumStarts = (psa_pkg::STRIP_LIMIT + CHANNEL_STRIPS)
		/ CHANNEL_STRIPS;
	localparam int ProdW = psa_pkg::ENERGY_W + psa_pkg::GAIN_W;
	localparam int AccW  = psa_pkg::ENERGY_W + 17;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL_E = 6'b000010,
		ST_MUL_P = 6'b000100,
		ST_SUM   = 6'b001000,
		ST_MUL_G = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	psa_pkg::cfg_t cfg;

	state_t                          state_q;
	logic [psa_pkg::ENERGY_W-1:0]    prev_energy_q;
	logic [psa_pkg::ENERGY_W-1:0]    energy_q;
	logic [psa_pkg::ENERGY_W-1:0]    start_q;
	logic [psa_pkg::GAIN_W-1:0]      gain_q;
	logic [psa_pkg::PED_W-1:0]       ped_q;
	logic [psa_pkg::SIDX_W-1:0]      last_idx_q;
	logic [psa_pkg::SIDX_W-1:0]      idx_q;
	logic [ProdW-1:0]                prod_q;
	logic [AccW-1:0]                 acc_q;
	logic [psa_pkg::ENERGY_W-1:0]    shaped_q;
	logic                            ovalid_q;
	logic [psa_pkg::COUNT_W-1:0]     count_q;
	logic [psa_pkg::SIDX_W-1:0]      oidx_q;
	logic                            olast_q;

	logic                            accept;
	logic                            chan_start;
	logic                            rate_ok;
	logic [psa_pkg::SIDX_W-1:0]      rate_last;
	logic [psa_pkg::CFG_W-1:0]       weight;
	logic [16:0]                     weight_c;
	logic [psa_pkg::ENERGY_W-1:0]    mul_a;
	logic [psa_pkg::GAIN_W-1:0]      mul_b;
	logic [AccW-1:0]                 sum;
	logic [32:0]                     raw_count;
	logic [psa_pkg::COUNT_W-1:0]     sat_count;
	logic                            out_free;

	psa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign strip.ready = (state_q == ST_IDLE);
	assign accept      = strip.valid && strip.ready;
	assign out_free    = !ovalid_q || sample.ready;

	// Flag the first strip of a channel
	always_comb begin
		chan_start = 1'b0;
		for (int k = 0; k < NumStarts; k++) begin
			if (strip.strip_index == psa_pkg::STRIP_W'(k * CHANNEL_STRIPS)) begin
				chan_start = 1'b1;
			end
		end
	end

	// Fold unsupported rates to a single sample
	assign rate_ok = (strip.sample_rate != 3'd0) && (strip.sample_rate <= 3'd4)
		&& ({1'b0, strip.sample_rate} <= 4'(MAX_SAMPLES));
	assign rate_last = rate_ok ? psa_pkg::SIDX_W'(strip.sample_rate - 3'd1) : '0;

	// Select the decay weight for sample idx of the strip
	always_comb begin
		case (last_idx_q)
			2'd1:    weight = (idx_q == 2'd0) ? cfg.decay_half : cfg.decay_full;
			2'd2: begin
				case (idx_q)
					2'd0:    weight = cfg.decay_third;
					2'd1:    weight = cfg.decay_two_thirds;
					default: weight = cfg.decay_full;
				endcase
			end
			default: begin
				case (idx_q)
					2'd0:    weight = cfg.decay_quarter;
					2'd1:    weight = cfg.decay_half;
					2'd2:    weight = cfg.decay_three_quarters;
					default: weight = cfg.decay_full;
				endcase
			end
		endcase
	end
	assign weight_c = 17'h10000 - {1'b0, weight};

	// Route operands to the shared multiplier
	always_comb begin
		unique case (state_q)
			ST_MUL_E: begin
				mul_a = energy_q;
				mul_b = {7'b0, weight_c};
			end
			ST_MUL_P: begin
				mul_a = start_q;
				mul_b = {8'b0, weight};
			end
			default: begin
				mul_a = shaped_q;
				mul_b = gain_q;
			end
		endcase
	end

	// Blend sum and saturated count
	assign sum       = acc_q + prod_q[AccW-1:0];
	assign raw_count = {1'b0, prod_q[ProdW-1:16]} + {17'b0, ped_q};
	assign sat_count = (raw_count > {17'b0, cfg.max_adc}) ? cfg.max_adc
		: raw_count[psa_pkg::COUNT_W-1:0];

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			energy_q <= strip.energy;
			start_q  <= chan_start ? '0 : prev_energy_q;
			gain_q   <= strip.gain;
			ped_q    <= strip.pedestal;
			shaped_q <= strip.energy;
		end
		if (state_q == ST_MUL_E || state_q == ST_MUL_P || state_q == ST_MUL_G) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_MUL_P) begin
			acc_q <= prod_q[AccW-1:0];
		end
		if (state_q == ST_SUM) begin
			shaped_q <= sum[AccW-2:16];
		end
		if (state_q == ST_EMIT && out_free) begin
			count_q <= sat_count;
			oidx_q  <= idx_q;
			olast_q <= (idx_q == last_idx_q);
		end
	end

	// Sequencer, previous energy and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_energy_q <= '0;
			last_idx_q    <= '0;
			idx_q         <= '0;
			ovalid_q      <= 1'b0;
		end else begin
			// Load a new sample, or drop the one just taken
			if (state_q == ST_EMIT && out_free) begin
				ovalid_q <= 1'b1;
			end else if (sample.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_energy_q <= strip.energy;
						last_idx_q    <= rate_last;
						idx_q         <= '0;
						state_q       <= rate_ok && (rate_last != '0) ? ST_MUL_E : ST_MUL_G;
					end
				end
				ST_MUL_E: state_q <= ST_MUL_P;
				ST_MUL_P: state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_MUL_G;
				ST_MUL_G: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						if (idx_q == last_idx_q) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_MUL_E;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample.valid        = ovalid_q;
	assign sample.adc_count    = count_q;
	assign sample.sample_index = oidx_q;
	assign sample.last_sample  = olast_q;

	// Checks
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !strip.ready)
		else $error("strip accepted while a strip is in progress");

	a_count_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid |-> (sample.adc_count <= cfg.max_adc))
		else $error("ADC count above saturation limit");

	a_idle_index_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == '0))
		else $error("sample index not cleared at end of strip");

	a_sample_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (idx_q <= last_idx_q))
		else $error("sample index beyond strip rate");

endmodule

// File: sv/psa_cfg_regs.sv
// ----------------------------------------------------------------------------
// psa_cfg_regs
// Configuration register file: saturation limit and the six decay weights.
// ----------------------------------------------------------------------------
module psa_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psa_pkg::CFG_W-1:0]       cfg_data,
	output psa_pkg::cfg_t                   cfg
);

	psa_pkg::cfg_t regs_q;

	// Decode the index and update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_adc              <= psa_pkg::RST_MAX_ADC;
			regs_q.decay_quarter        <= psa_pkg::RST_DECAY_QUARTER;
			regs_q.decay_third          <= psa_pkg::RST_DECAY_THIRD;
			regs_q.decay_half           <= psa_pkg::RST_DECAY_HALF;
			regs_q.decay_two_thirds     <= psa_pkg::RST_DECAY_TWO_THIRDS;
			regs_q.decay_three_quarters <= psa_pkg::RST_DECAY_THREE_QUARTERS;
			regs_q.decay_full           <= psa_pkg::RST_DECAY_FULL;
		end else if (cfg_we) begin
			unique case (psa_pkg::cfg_reg_t'(cfg_index))
				psa_pkg::REG_MAX_ADC:              regs_q.max_adc <= cfg_data;
				psa_pkg::REG_DECAY_QUARTER:        regs_q.decay_quarter <= cfg_data;
				psa_pkg::REG_DECAY_THIRD:          regs_q.decay_third <= cfg_data;
				psa_pkg::REG_DECAY_HALF:           regs_q.decay_half <= cfg_data;
				psa_pkg::REG_DECAY_TWO_THIRDS:     regs_q.decay_two_thirds <= cfg_data;
				psa_pkg::REG_DECAY_THREE_QUARTERS: regs_q.decay_three_quarters <= cfg_data;
				psa_pkg::REG_DECAY_FULL:           regs_q.decay_full <= cfg_data;
				default: begin
					// unused index: drop the write
				end
			endcase
		end
	end

	assign cfg = regs_q;

endmodule
